>>> design/sws_pkg.sv
package sws_pkg;

	localparam int MAX_SIDE_DEF  = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CMD_DEPTH     = 4;
	localparam int RES_DEPTH     = 8;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_COS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_SIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_W     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_H     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_RB   = 3'd6;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       inside_res;
	} out_word_t;

	// queued command: pixel packed red in the low byte
	typedef struct packed {
		logic        sample;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [23:0] pix;
	} cmd_t;

	typedef struct packed {
		logic [31:0] scale_cos;
		logic [31:0] scale_sin;
		logic [31:0] shift_x;
		logic [31:0] shift_y;
		logic [8:0]  src_width;
		logic [8:0]  src_height;
		logic        swap_rb;
	} cfg_t;

endpackage

>>> design/sws_ram.sv
module sws_ram #(
	parameter int W  = 24,
	parameter int AW = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	localparam int DEPTH = 1 << AW;

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/sws_fifo.sv
module sws_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

endmodule

>>> design/sws_front.sv
module sws_front
	import sws_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  in_word_t item,
	input  logic     accept,
	output logic     cmd_push,
	output cmd_t     cmd
);

	logic keep;

	// drop loads that fall outside the store
	always_comb begin
		keep = (item.op == OP_SAMPLE) ||
			((32'(item.pos_x) < MAX_SIDE) && (32'(item.pos_y) < MAX_SIDE));
		cmd_push   = accept && keep;
		cmd.sample = (item.op == OP_SAMPLE);
		cmd.x      = item.pos_x;
		cmd.y      = item.pos_y;
		cmd.pix    = {item.blue_in, item.green_in, item.red_in};
	end

endmodule

>>> design/sws_back.sv
module sws_back
	import sws_pkg::*;
#(
	parameter int MAX_SIDE  = MAX_SIDE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  cmd_t      cmd,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	input  logic      res_pop,
	output logic      res_push,
	output out_word_t res_word
);

	localparam int CW     = $clog2(MAX_SIDE);
	localparam int HALF_W = (CW > 1) ? CW - 1 : 1;
	localparam int BAW    = 2 * HALF_W;
	localparam int PW     = 41;
	localparam int SW     = 44;
	localparam int TW     = FRAC_BITS + 9;
	localparam int VW     = TW + FRAC_BITS + 2;
	localparam int CRW    = $clog2(RES_DEPTH + 1);
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
	localparam logic [VW-1:0] HALF = VW'(1) << (2 * FRAC_BITS - 1);

	// credit: samples issued and not yet taken by the consumer
	logic [CRW-1:0] credit_q;
	logic issue;

	assign issue   = !cmd_empty && (!cmd.sample || credit_q < CRW'(RES_DEPTH));
	assign cmd_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CRW'(issue && cmd.sample) - CRW'(res_pop);
		end
	end

	// stage 1: four coefficient products
	logic v_s1, smp_s1;
	logic [7:0] x_s1, y_s1;
	logic [23:0] pix_s1;
	logic signed [PW-1:0] pcx_s1, psy_s1, pcy_s1, psx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			smp_s1 <= cmd.sample;
			x_s1   <= cmd.x;
			y_s1   <= cmd.y;
			pix_s1 <= cmd.pix;
			pcx_s1 <= $signed(cfg.scale_cos) * $signed({1'b0, cmd.x});
			psy_s1 <= $signed(cfg.scale_sin) * $signed({1'b0, cmd.y});
			pcy_s1 <= $signed(cfg.scale_cos) * $signed({1'b0, cmd.y});
			psx_s1 <= $signed(cfg.scale_sin) * $signed({1'b0, cmd.x});
		end
	end

	// stage 2: source coordinates
	logic v_s2, smp_s2;
	logic [7:0] x_s2, y_s2;
	logic [23:0] pix_s2;
	logic signed [SW-1:0] sx_s2, sy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		smp_s2 <= smp_s1;
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		pix_s2 <= pix_s1;
		sx_s2  <= SW'(pcx_s1) + SW'(psy_s1) + SW'($signed(cfg.shift_x));
		sy_s2  <= SW'(pcy_s1) - SW'(psx_s1) + SW'($signed(cfg.shift_y));
	end

	// stage 3: inside test, neighbours, store access
	logic [CW:0] w_eff, h_eff;
	logic [SW-1:0] lim_x, lim_y;
	logic in_img;
	logic [CW-1:0] x0, y0, x1, y1;
	logic [CW-1:0] lx, ly;
	logic [FRAC_BITS-1:0] dx, dy;

	always_comb begin
		if (cfg.src_width == '0) w_eff = (CW+1)'(1);
		else if (32'(cfg.src_width) > MAX_SIDE) w_eff = (CW+1)'(MAX_SIDE);
		else w_eff = (CW+1)'(cfg.src_width);
		if (cfg.src_height == '0) h_eff = (CW+1)'(1);
		else if (32'(cfg.src_height) > MAX_SIDE) h_eff = (CW+1)'(MAX_SIDE);
		else h_eff = (CW+1)'(cfg.src_height);
		lim_x  = SW'(w_eff - 1'b1) << FRAC_BITS;
		lim_y  = SW'(h_eff - 1'b1) << FRAC_BITS;
		in_img = !sx_s2[SW-1] && !sy_s2[SW-1] &&
			(sx_s2 <= $signed(lim_x)) && (sy_s2 <= $signed(lim_y));
		x0 = sx_s2[FRAC_BITS +: CW];
		y0 = sy_s2[FRAC_BITS +: CW];
		x1 = (({1'b0, x0} + 1'b1) < w_eff) ? x0 + 1'b1 : CW'(w_eff - 1'b1);
		y1 = (({1'b0, y0} + 1'b1) < h_eff) ? y0 + 1'b1 : CW'(h_eff - 1'b1);
		dx = sx_s2[FRAC_BITS-1:0];
		dy = sy_s2[FRAC_BITS-1:0];
		lx = CW'(x_s2);
		ly = CW'(y_s2);
	end

	// four banks by row and column parity: bank index {row[0], col[0]}
	logic [BAW-1:0] bank_raddr [4];
	logic [23:0]    bank_rdata [4];
	logic [BAW-1:0] load_addr;
	logic [1:0]     load_bank;

	assign load_addr = {HALF_W'(ly >> 1), HALF_W'(lx >> 1)};
	assign load_bank = {ly[0], lx[0]};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [CW-1:0] row, col;
		always_comb begin
			row = (y0[0] == 1'(b / 2)) ? y0 : y1;
			col = (x0[0] == 1'(b % 2)) ? x0 : x1;
			bank_raddr[b] = {HALF_W'(row >> 1), HALF_W'(col >> 1)};
		end
		sws_ram #(.W(24), .AW(BAW)) u_ram (
			.clk  (clk),
			.we   (v_s2 && !smp_s2 && (load_bank == 2'(b))),
			.waddr(load_addr),
			.wdata(pix_s2),
			.raddr(bank_raddr[b]),
			.rdata(bank_rdata[b])
		);
	end

	logic v_s3, inside_s3;
	logic [1:0] b00_s3, b01_s3, b10_s3, b11_s3;
	logic [FRAC_BITS-1:0] dx_s3, dy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2 && smp_s2;
		end
	end

	always_ff @(posedge clk) begin
		inside_s3 <= in_img;
		b00_s3    <= {y0[0], x0[0]};
		b01_s3    <= {y0[0], x1[0]};
		b10_s3    <= {y1[0], x0[0]};
		b11_s3    <= {y1[0], x1[0]};
		dx_s3     <= dx;
		dy_s3     <= dy;
	end

	// stage 4: horizontal blend
	logic v_s4, inside_s4;
	logic [FRAC_BITS-1:0] dy_s4;
	logic [TW-1:0] top_s4 [3];
	logic [TW-1:0] bot_s4 [3];
	logic [FRAC_BITS:0] wx;
	logic [23:0] p00, p01, p10, p11;

	always_comb begin
		wx  = ONE - {1'b0, dx_s3};
		p00 = bank_rdata[b00_s3];
		p01 = bank_rdata[b01_s3];
		p10 = bank_rdata[b10_s3];
		p11 = bank_rdata[b11_s3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		inside_s4 <= inside_s3;
		dy_s4     <= dy_s3;
		for (int k = 0; k < 3; k++) begin
			top_s4[k] <= TW'(p00[8*k +: 8]) * TW'(wx) + TW'(p01[8*k +: 8]) * TW'(dx_s3);
			bot_s4[k] <= TW'(p10[8*k +: 8]) * TW'(wx) + TW'(p11[8*k +: 8]) * TW'(dx_s3);
		end
	end

	// stage 5: vertical blend
	logic v_s5, inside_s5;
	logic [VW-1:0] acc_s5 [3];
	logic [FRAC_BITS:0] wy;

	assign wy = ONE - {1'b0, dy_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		inside_s5 <= inside_s4;
		for (int k = 0; k < 3; k++) begin
			acc_s5[k] <= VW'(top_s4[k]) * VW'(wy) + VW'(bot_s4[k]) * VW'(dy_s4);
		end
	end

	// round half up, saturate, blank outside points, optional swap
	logic [VW-1:0] rnd [3];
	logic [7:0] chan [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rnd[k] = (acc_s5[k] + HALF) >> (2 * FRAC_BITS);
			if (!inside_s5) chan[k] = 8'd0;
			else if (rnd[k] > VW'(255)) chan[k] = 8'hFF;
			else chan[k] = rnd[k][7:0];
		end
		res_push            = v_s5;
		res_word.red_out    = cfg.swap_rb ? chan[2] : chan[0];
		res_word.green_out  = chan[1];
		res_word.blue_out   = cfg.swap_rb ? chan[0] : chan[2];
		res_word.inside_res = inside_s5;
	end

endmodule

>>> design/similarity_warp_bilinear_sampler.sv
// A sample word passes the command queue, then the products, coordinates, store read,
// horizontal blend and vertical blend stages, and last the result queue.
// Throughput: one word per cycle, loads and samples alike, while the command queue has room
// and, for samples, a result slot is free; the four parity banks of the pixel store give
// the four neighbor reads in the same cycle.
// Reset: configuration returns to identity map, 256 x 256, no swap; queues empty.
// Pixel store contents are undefined after reset until written.
module similarity_warp_bilinear_sampler
	import sws_pkg::*;
#(
	parameter int MAX_SIDE  = MAX_SIDE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  in_word_t             item,
	output logic                 empty,
	input  logic                 pop,
	output out_word_t            result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	// Configuration registers; the port always takes a write.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_cos  <= 32'h0001_0000;
			cfg_q.scale_sin  <= '0;
			cfg_q.shift_x    <= '0;
			cfg_q.shift_y    <= '0;
			cfg_q.src_width  <= 9'd256;
			cfg_q.src_height <= 9'd256;
			cfg_q.swap_rb    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCALE_COS: cfg_q.scale_cos <= cfg_data;
				REG_SCALE_SIN: cfg_q.scale_sin <= cfg_data;
				REG_SHIFT_X:   cfg_q.shift_x <= cfg_data;
				REG_SHIFT_Y:   cfg_q.shift_y <= cfg_data;
				REG_SRC_W:     cfg_q.src_width <= cfg_data[8:0];
				REG_SRC_H:     cfg_q.src_height <= cfg_data[8:0];
				REG_SWAP_RB:   cfg_q.swap_rb <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front: classify the incoming word and drop loads outside the store.
	logic cmd_push, cmd_full, cmd_empty, cmd_pop;
	cmd_t cmd_in, cmd_head;

	assign full = cmd_full;

	sws_front #(.MAX_SIDE(MAX_SIDE)) u_front (
		.item    (item),
		.accept  (push && !cmd_full),
		.cmd_push(cmd_push),
		.cmd     (cmd_in)
	);

	// Short command queue: lets the front keep taking words while the back stalls.
	sws_fifo #(.W($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_head),
		.empty (cmd_empty)
	);

	// Back: map, fetch the four neighbors, blend. It issues a sample only when a result
	// slot is reserved, so the pipeline itself never has to stall.
	logic res_push, res_full, res_pop;
	out_word_t res_word;

	assign res_pop = pop && !empty;

	sws_back #(.MAX_SIDE(MAX_SIDE), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd_head),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_pop  (res_pop),
		.res_push (res_push),
		.res_word (res_word)
	);

	// Result queue: holds finished words until the consumer pops them.
	sws_fifo #(.W($bits(out_word_t)), .DEPTH(RES_DEPTH)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_word),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

	// Credit scheme must never overrun the result queue.
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result queue overrun");

	a_cmd_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command queue popped while empty");

	// Points outside the source must come out black.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.inside_res) |->
		(result.red_out == 8'd0 && result.green_out == 8'd0 && result.blue_out == 8'd0))
		else $error("outside point not black");

endmodule

>>> verif/similarity_warp_bilinear_sampler_test.sv
`timescale 1ns / 1ps

module similarity_warp_bilinear_sampler_test;
	import sws_pkg::*;

	localparam int SIDE       = 256;
	localparam int FRAC       = 16;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_WAIT = 12;

	// Clamp a raw size register the way the block does: zero means one, above SIDE means SIDE.
	function automatic int side_of(bit [8:0] raw);
		if (raw == 0) begin
			return 1;
		end
		if (raw > SIDE) begin
			return SIDE;
		end
		return int'(raw);
	endfunction

	// Scoreboard: keeps a private copy of the pixel store and the map registers,
	// predicts each sample word, and holds the predicted words in arrival order.
	class warp_scoreboard;
		bit [23:0]   pixels [0:SIDE*SIDE-1];
		bit [31:0]   cos_reg = 32'd65536;
		bit [31:0]   sin_reg = '0;
		bit [31:0]   tx_reg  = '0;
		bit [31:0]   ty_reg  = '0;
		bit [8:0]    w_reg   = 9'd256;
		bit [8:0]    h_reg   = 9'd256;
		bit          swap    = 1'b0;
		out_word_t   pending [$];
		int          errors;
		int          mismatches;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_SCALE_COS: cos_reg = data;
				REG_SCALE_SIN: sin_reg = data;
				REG_SHIFT_X:   tx_reg  = data;
				REG_SHIFT_Y:   ty_reg  = data;
				REG_SRC_W:     w_reg   = data[8:0];
				REG_SRC_H:     h_reg   = data[8:0];
				REG_SWAP_RB:   swap    = data[0];
				default: ;
			endcase
		endfunction

		function void note_word(in_word_t w);
			longint px, py, cc, ss, sx, sy, wd, ht, x0, y0, x1, y1, dx, dy;
			longint top, bot, v, one;
			bit [23:0] p00, p01, p10, p11;
			bit [7:0] rgb [3];
			out_word_t exp_word;
			if (w.op == OP_LOAD) begin
				pixels[{w.pos_y, w.pos_x}] = {w.blue_in, w.green_in, w.red_in};
				return;
			end
			px = w.pos_x;
			py = w.pos_y;
			cc = longint'($signed(cos_reg));
			ss = longint'($signed(sin_reg));
			wd = side_of(w_reg);
			ht = side_of(h_reg);
			one = longint'(1) << FRAC;
			sx = cc * px + ss * py + longint'($signed(tx_reg));
			sy = cc * py - ss * px + longint'($signed(ty_reg));
			exp_word = '0;
			rgb[0] = 0;
			rgb[1] = 0;
			rgb[2] = 0;
			if (sx >= 0 && sy >= 0 && sx <= (wd - 1) * one && sy <= (ht - 1) * one) begin
				x0 = sx >>> FRAC;
				y0 = sy >>> FRAC;
				x1 = (x0 + 1 < wd) ? x0 + 1 : wd - 1;
				y1 = (y0 + 1 < ht) ? y0 + 1 : ht - 1;
				dx = sx & (one - 1);
				dy = sy & (one - 1);
				p00 = pixels[y0 * SIDE + x0];
				p01 = pixels[y0 * SIDE + x1];
				p10 = pixels[y1 * SIDE + x0];
				p11 = pixels[y1 * SIDE + x1];
				for (int k = 0; k < 3; k++) begin
					top = longint'((p00 >> (8 * k)) & 8'hff) * (one - dx)
						+ longint'((p01 >> (8 * k)) & 8'hff) * dx;
					bot = longint'((p10 >> (8 * k)) & 8'hff) * (one - dx)
						+ longint'((p11 >> (8 * k)) & 8'hff) * dx;
					v = top * (one - dy) + bot * dy;
					v = (v + (longint'(1) << (2 * FRAC - 1))) >> (2 * FRAC);
					rgb[k] = (v > 255) ? 8'd255 : v[7:0];
				end
				exp_word.inside_res = 1'b1;
			end
			exp_word.red_out   = swap ? rgb[2] : rgb[0];
			exp_word.green_out = rgb[1];
			exp_word.blue_out  = swap ? rgb[0] : rgb[2];
			pending.push_back(exp_word);
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("unexpected result word %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.red_out !== want.red_out || got.green_out !== want.green_out
					|| got.blue_out !== want.blue_out || got.inside_res !== want.inside_res) begin
				errors++;
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected r=%0d g=%0d b=%0d in=%0d, got r=%0d g=%0d b=%0d in=%0d",
						want.red_out, want.green_out, want.blue_out, want.inside_res,
						got.red_out, got.green_out, got.blue_out, got.inside_res);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	in_word_t             item;
	logic                 empty;
	logic                 pop;
	out_word_t            result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	warp_scoreboard sb = new();
	bit send_steady;   // drop sender gaps for this phase
	bit pop_steady;    // drop receiver stalls for this phase
	int idle_cycles;

	similarity_warp_bilinear_sampler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Push one word: draw a gap, then hold push until the block takes the word.
	// Keep push high across back-to-back words so it never toggles twice in one step.
	task automatic send_word(in_word_t w);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		sb.note_word(w);
	endtask

	// Wait until every predicted word has come back, then let in-flight loads settle.
	task automatic drain();
		push <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Write one register; leave valid high unless this is the last write of the group.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		if (last) begin
			cfg_valid <= 1'b0;
		end
	endtask

	task automatic set_map(bit [31:0] c, bit [31:0] s, bit [31:0] tx, bit [31:0] ty,
			bit [8:0] w, bit [8:0] h, bit sw);
		drain();
		cfg_write(REG_SCALE_COS, c, 1'b0);
		cfg_write(REG_SCALE_SIN, s, 1'b0);
		cfg_write(REG_SHIFT_X, tx, 1'b0);
		cfg_write(REG_SHIFT_Y, ty, 1'b0);
		cfg_write(REG_SRC_W, {23'd0, w}, 1'b0);
		cfg_write(REG_SRC_H, {23'd0, h}, 1'b0);
		cfg_write(REG_SWAP_RB, {31'd0, sw}, 1'b1);
	endtask

	function automatic in_word_t load_word(int x, int y);
		in_word_t w;
		w.op       = OP_LOAD;
		w.pos_x    = 8'(x);
		w.pos_y    = 8'(y);
		w.red_in   = 8'($urandom_range(0, 255));
		w.green_in = 8'($urandom_range(0, 255));
		w.blue_in  = 8'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic in_word_t sample_word(int x, int y);
		in_word_t w;
		w = load_word(x, y);
		w.op = OP_SAMPLE;
		return w;
	endfunction

	// Fill the whole active source area so that no sample reads an unwritten pixel.
	task automatic fill_source();
		int wd, ht;
		wd = side_of(sb.w_reg);
		ht = side_of(sb.h_reg);
		for (int y = 0; y < ht; y++) begin
			for (int x = 0; x < wd; x++) begin
				send_word(load_word(x, y));
			end
		end
	endtask

	// Mix samples with reloads inside the active area; optionally hold off halfway
	// until every pending result has drained.
	task automatic mixed_traffic(int samples, bit hold_off);
		int wd, ht;
		wd = side_of(sb.w_reg);
		ht = side_of(sb.h_reg);
		for (int i = 0; i < samples; i++) begin
			if (hold_off && i == samples / 2) begin
				push <= 1'b0;
				do @(posedge clk); while (sb.pending.size() != 0);
			end
			if ($urandom_range(0, 3) == 0) begin
				send_word(load_word($urandom_range(0, wd - 1), $urandom_range(0, ht - 1)));
			end
			send_word(sample_word($urandom_range(0, 255), $urandom_range(0, 255)));
		end
	endtask

	// Receiver: draw a stall per word, then take it and check it.
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = pop_steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_word(result);
		end
	end

	// Watchdog: end the run if no handshake completes for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int wr, hr, wd, ht, rng;
		bit [31:0] c, s, tx, ty;
		arst_n    = 1'b0;
		push      = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SCALE_COS;
		cfg_data  = '0;
		idle_cycles = 0;
		send_steady = 1'b0;
		pop_steady  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity map on a 4 x 4 image: three corners, with the clamped last row and column,
		// points just outside on the right and bottom edges, and one point far outside.
		set_map(32'd65536, 32'd0, 32'd0, 32'd0, 9'd4, 9'd4, 1'b0);
		fill_source();
		send_word(sample_word(0, 0));
		send_word(sample_word(3, 3));
		send_word(sample_word(3, 0));
		send_word(sample_word(4, 0));
		send_word(sample_word(0, 4));
		send_word(sample_word(255, 255));

		// Half-pixel shift exercises round-half-up; swap red and blue at the same time.
		set_map(32'd65536, 32'd0, 32'h0000_8000, 32'h0000_8000, 9'd4, 9'd4, 1'b1);
		send_word(sample_word(0, 0));
		send_word(sample_word(2, 1));
		send_word(sample_word(3, 3));
		// Negative shift lands just left of the image.
		set_map(32'd65536, 32'd0, 32'hffff_ffff, 32'd0, 9'd4, 9'd4, 1'b0);
		send_word(sample_word(0, 0));
		send_word(sample_word(1, 2));

		// Zero width counts as one, oversized height counts as the full side.
		set_map(32'd0, 32'd65536, 32'd0, 32'd0, 9'd0, 9'd511, 1'b1);
		fill_source();
		mixed_traffic(20, 1'b0);

		// Full width, one row; extreme coefficients overflow 32 bits in the products.
		set_map(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 9'd256, 9'd1, 1'b0);
		fill_source();
		mixed_traffic(10, 1'b0);
		set_map(32'd65536, 32'd0, 32'd0, 32'd0, 9'd256, 9'd1, 1'b0);
		mixed_traffic(20, 1'b0);

		// Random phases: small images, maps scaled so many samples land inside.
		for (int ph = 0; ph < 4; ph++) begin
			case ($urandom_range(0, 7))
				0: wr = 0;
				default: wr = $urandom_range(1, 6);
			endcase
			case ($urandom_range(0, 7))
				0: hr = 0;
				default: hr = $urandom_range(1, 6);
			endcase
			wd = side_of(9'(wr));
			ht = side_of(9'(hr));
			rng = ((wd > ht ? wd : ht) << FRAC) / 300 + 1;
			c  = $urandom_range(0, 2 * rng) - rng;
			s  = $urandom_range(0, 2 * rng) - rng;
			tx = ((wd - 1) << (FRAC - 1)) + $urandom_range(0, wd << FRAC) - (wd << (FRAC - 1));
			ty = ((ht - 1) << (FRAC - 1)) + $urandom_range(0, ht << FRAC) - (ht << (FRAC - 1));
			send_steady = ($urandom_range(0, 3) == 0);
			pop_steady  = ($urandom_range(0, 3) == 0);
			set_map(c, s, tx, ty, 9'(wr), 9'(hr), 1'($urandom_range(0, 1)));
			fill_source();
			mixed_traffic(30, ph == 1);
		end

		// Let everything drain, then allow for the pipeline latency.
		push <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> sim.f
design/sws_pkg.sv
design/sws_ram.sv
design/sws_fifo.sv
design/sws_front.sv
design/sws_back.sv
design/similarity_warp_bilinear_sampler.sv
verif/similarity_warp_bilinear_sampler_test.sv
